// ===== rtl/lr4x_pkg.sv =====
// Shared types and constants for the three-band LR4 crossover.
package lr4x_pkg;

  localparam int NUM_REGS  = 8;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 24;
  localparam int BCOEF_W   = 20;
  localparam int ACOEF_W   = 24;
  localparam int PROD_W    = DATA_W + COEF_W;
  localparam int ACC_W     = 62;
  localparam int MEM_DEPTH = 30;
  localparam int ADDR_W    = 5;
  localparam int H_BASE    = 6;
  localparam int G_BASE    = 18;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_RND,
    ST_WR,
    ST_XWR,
    ST_STAGE,
    ST_OUT
  } lr4x_state_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic is_b;
  } lr4x_mac_ctrl_t;

endpackage

// ===== rtl/lr4x_mac.sv =====
// Shared multiply-accumulate with Q4.28 rounding and saturation.
module lr4x_mac
  import lr4x_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  lr4x_mac_ctrl_t           ctrl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] res
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic                     pb_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  term;
  logic signed [39:0]       rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctrl.mul;
    end
    prod_r <= coef * data;
    pb_r   <= ctrl.is_b;
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + term;
    end
  end

  // b terms carry four fewer fraction bits than a terms
  assign term = pb_r ? (ACC_W'(prod_r) <<< 4) : -ACC_W'(prod_r);

  always_comb begin
    rnd = 40'((acc_r + (ACC_W'(1) <<< 21)) >>> 22);
    if (rnd > 40'sh007FFFFFFF) begin
      res = 32'sh7FFFFFFF;
    end else if (rnd < -40'sh0080000000) begin
      res = -32'sh80000000;
    end else begin
      res = rnd[DATA_W-1:0];
    end
  end

endmodule

// ===== rtl/three_band_lr4_crossover_core.sv =====
// Top level of the three-band LR4 crossover: sequencer, history memory, registers.
// Usage: write the eight coefficient registers through cfg_we/cfg_index/cfg_wdata
// while idle; indexes beyond the list are dropped. Samples enter on in_valid/in_ready,
// each transfer yields one result transfer of three bands on out_valid/out_ready.
// All filter history lives in one 30-word single-port memory with registered reads;
// a single 24x32 multiplier with a registered accumulator computes every product.
// Each biquad takes five products, and each of the 12 biquads needs its history
// loaded and written back through the one memory port, so an item is worked through
// in full, up to its result, before the next item can be taken.
// in_ready is high only while the sequencer is idle. A finished result is held in the
// output register; the next item may be accepted while it waits, and that item's
// result waits in turn until the previous one has been transferred.
// Synchronous reset (rst_n low) clears the registers, drops any pending result and
// marks every history word invalid, so unwritten words read as zero; no clearing
// pass is needed.
module three_band_lr4_crossover_core
  import lr4x_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_band_low,
  output logic signed [SAMPLE_BITS-1:0] out_band_mid,
  output logic signed [SAMPLE_BITS-1:0] out_band_high,
  input  logic                          cfg_we,
  input  logic [3:0]                    cfg_index,
  input  logic [59:0]                   cfg_wdata
);

  localparam int UP = (SAMPLE_BITS <= 29) ? 29 - SAMPLE_BITS : 0;
  localparam int DN = (SAMPLE_BITS > 29) ? SAMPLE_BITS - 29 : 0;
  localparam logic signed [39:0] RND40 = (40'sd1 <<< UP) >>> 1;
  localparam logic signed [39:0] OMAX  = (40'sd1 <<< (SAMPLE_BITS - 1)) - 40'sd1;
  localparam logic signed [39:0] OMIN  = -(40'sd1 <<< (SAMPLE_BITS - 1));

  function automatic logic signed [SAMPLE_BITS-1:0] to_smp(input logic signed [31:0] v);
    logic signed [39:0] t;
    t = ((40'(v) + RND40) >>> UP) <<< DN;
    if (t > OMAX) begin
      t = OMAX;
    end else if (t < OMIN) begin
      t = OMIN;
    end
    return t[SAMPLE_BITS-1:0];
  endfunction

  // coefficient registers
  logic [59:0] b_r [4];
  logic [47:0] a_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        b_r[i] <= '0;
        a_r[i] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < NUM_REGS)) begin
      if (cfg_index[0]) begin
        a_r[cfg_index[2:1]] <= cfg_wdata[47:0];
      end else begin
        b_r[cfg_index[2:1]] <= cfg_wdata;
      end
    end
  end

  // sequencer state
  lr4x_state_t state_r, state_nxt;
  logic [1:0]  stage_r;
  logic        filt_r;
  logic        sec_r;
  logic [2:0]  k_r;

  logic signed [DATA_W-1:0] xs_r, hi_r, lp_r, hp_r, low_r, y_r, z_r;
  logic signed [DATA_W-1:0] op_r [6];
  logic                     pend_r;
  logic                     out_load;

  // history memory
  logic [DATA_W-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [DATA_W-1:0]    rd_r;
  logic                 rv_r;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [DATA_W-1:0]    mem_wdata;
  logic signed [DATA_W-1:0] rdata;

  logic [ADDR_W-1:0] fbase;
  logic [1:0]        fsel;
  logic [59:0]       bsel;
  logic [47:0]       asel;

  lr4x_mac_ctrl_t           mac_ctrl;
  logic signed [COEF_W-1:0] mac_coef;
  logic signed [DATA_W-1:0] mac_data;
  logic signed [DATA_W-1:0] mac_res;

  logic signed [DATA_W:0]   sum33;
  logic signed [DATA_W-1:0] sum_sat;
  logic signed [DATA_W-1:0] x_in;

  assign fbase = ADDR_W'({stage_r, filt_r, 1'b0});
  assign fsel  = {(stage_r != 2'd0), filt_r};
  assign bsel  = b_r[fsel];
  assign asel  = a_r[fsel];
  assign rdata = rv_r ? rd_r : '0;
  assign x_in  = (DATA_W'(in_sample_in) <<< UP) >>> DN;

  // move a finished result into the output register once it is free
  assign out_load = (state_r == ST_OUT) && pend_r && (!out_valid || out_ready);

  assign sum33   = {lp_r[DATA_W-1], lp_r} + {hp_r[DATA_W-1], hp_r};
  assign sum_sat = (sum33[DATA_W] != sum33[DATA_W-1]) ?
                   {sum33[DATA_W], {(DATA_W-1){~sum33[DATA_W]}}} : sum33[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      rv_r <= vld_r[mem_addr];
      if (mem_we) begin
        vld_r[mem_addr] <= 1'b1;
      end
    end
  end

  lr4x_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .coef  (mac_coef),
    .data  (mac_data),
    .res   (mac_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD:  if (k_r == 3'd6) state_nxt = ST_MAC;
      ST_MAC:   if (k_r == 3'd5) state_nxt = ST_RND;
      ST_RND:   state_nxt = sec_r ? ST_WR : ST_MAC;
      ST_WR:    if (k_r == 3'd3) state_nxt = filt_r ? ST_XWR : ST_LOAD;
      ST_XWR:   if (k_r == 3'd1) state_nxt = ST_STAGE;
      ST_STAGE: state_nxt = (stage_r == 2'd2) ? ST_OUT : ST_LOAD;
      ST_OUT:   if (!pend_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs: memory port and multiplier feed
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    mac_ctrl  = '0;
    mac_coef  = '0;
    mac_data  = '0;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_LOAD: begin
        case (k_r)
          3'd0:    mem_addr = ADDR_W'({stage_r, 1'b0});
          3'd1:    mem_addr = ADDR_W'({stage_r, 1'b1});
          3'd2:    mem_addr = fbase + ADDR_W'(H_BASE);
          3'd3:    mem_addr = fbase + ADDR_W'(H_BASE + 1);
          3'd4:    mem_addr = fbase + ADDR_W'(G_BASE);
          3'd5:    mem_addr = fbase + ADDR_W'(G_BASE + 1);
          default: mem_addr = '0;
        endcase
      end
      ST_MAC: begin
        mac_ctrl.clr  = (k_r == 3'd0);
        mac_ctrl.mul  = (k_r < 3'd5);
        mac_ctrl.is_b = (k_r < 3'd3);
        case (k_r)
          3'd0:    mac_coef = COEF_W'($signed(bsel[19:0]));
          3'd1:    mac_coef = COEF_W'($signed(bsel[39:20]));
          3'd2:    mac_coef = COEF_W'($signed(bsel[59:40]));
          3'd3:    mac_coef = $signed(asel[23:0]);
          3'd4:    mac_coef = $signed(asel[47:24]);
          default: mac_coef = '0;
        endcase
        case (k_r)
          3'd0:    mac_data = sec_r ? y_r : xs_r;
          3'd1:    mac_data = sec_r ? op_r[2] : op_r[0];
          3'd2:    mac_data = sec_r ? op_r[3] : op_r[1];
          3'd3:    mac_data = sec_r ? op_r[4] : op_r[2];
          3'd4:    mac_data = sec_r ? op_r[5] : op_r[3];
          default: mac_data = '0;
        endcase
      end
      ST_WR: begin
        mem_we = 1'b1;
        case (k_r)
          3'd0: begin
            mem_addr  = fbase + ADDR_W'(H_BASE + 1);
            mem_wdata = op_r[2];
          end
          3'd1: begin
            mem_addr  = fbase + ADDR_W'(H_BASE);
            mem_wdata = y_r;
          end
          3'd2: begin
            mem_addr  = fbase + ADDR_W'(G_BASE + 1);
            mem_wdata = op_r[4];
          end
          default: begin
            mem_addr  = fbase + ADDR_W'(G_BASE);
            mem_wdata = z_r;
          end
        endcase
      end
      ST_XWR: begin
        mem_we = 1'b1;
        if (k_r == 3'd0) begin
          mem_addr  = ADDR_W'({stage_r, 1'b1});
          mem_wdata = op_r[0];
        end else begin
          mem_addr  = ADDR_W'({stage_r, 1'b0});
          mem_wdata = xs_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      stage_r   <= '0;
      filt_r    <= 1'b0;
      sec_r     <= 1'b0;
      k_r       <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= (state_nxt != state_r) ? 3'd0 : k_r + 3'd1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          stage_r <= '0;
          filt_r  <= 1'b0;
          sec_r   <= 1'b0;
        end
        ST_RND:  sec_r <= ~sec_r;
        ST_WR:   if (k_r == 3'd3) filt_r <= ~filt_r;
        ST_STAGE: begin
          stage_r <= stage_r + 2'd1;
          if (stage_r == 2'd2) begin
            pend_r <= 1'b1;
          end
        end
        ST_OUT: begin
          // hold the result until the output register is free
          if (out_load) begin
            pend_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      xs_r <= x_in;
    end
    if ((state_r == ST_LOAD) && (k_r != 3'd0)) begin
      op_r[k_r - 3'd1] <= rdata;
    end
    if (state_r == ST_RND) begin
      if (sec_r) begin
        z_r <= mac_res;
      end else begin
        y_r <= mac_res;
      end
    end
    if ((state_r == ST_WR) && (k_r == 3'd3)) begin
      if (filt_r) begin
        hp_r <= z_r;
      end else begin
        lp_r <= z_r;
      end
    end
    if (state_r == ST_STAGE) begin
      case (stage_r)
        2'd0: begin
          xs_r <= lp_r;
          hi_r <= hp_r;
        end
        2'd1: begin
          low_r <= sum_sat;
          xs_r  <= hi_r;
        end
        default: ;
      endcase
    end
    if (out_load) begin
      out_band_low  <= to_smp(low_r);
      out_band_mid  <= to_smp(lp_r);
      out_band_high <= to_smp(hp_r);
    end
  end

endmodule
